>>> rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int KIND_W  = 3;
    localparam int POINT_W = 21;

    typedef enum logic [KIND_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_NULL     = 3'd1,
        ERR_TRUNC    = 3'd2,
        ERR_BAD_CONT = 3'd3,
        ERR_BAD_LEAD = 3'd4,
        ERR_OVER_MAX = 3'd5
    } err_kind_t;

    localparam logic [POINT_W-1:0] MAX_POINT = 21'h10FFFF;
    localparam logic [POINT_W-1:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;  // 0xD800 >> 10
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;  // 0xDC00 >> 10

    // One decoded event handed from the front to the back.
    typedef struct packed {
        err_kind_t          kind;
        logic [POINT_W-1:0] point;
        logic               eos;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } entry_bus_t;

endpackage

>>> rtl/u8u16_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, gathers code points and classifies errors.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_accept,
    input  logic [u8u16_pkg::BYTE_W-1:0]      in_byte,
    input  logic                              in_eos,
    output u8u16_pkg::entry_bus_t             push
);
    import u8u16_pkg::*;

    logic [1:0]         pending_reg, pending_next;
    logic [POINT_W-1:0] partial_reg, partial_next;
    logic               discard_reg, discard_next;

    logic [POINT_W-1:0] shifted;
    logic [1:0]         pend_dec;
    logic               do_push;
    err_kind_t          kind;
    logic [POINT_W-1:0] point;

    assign shifted  = {partial_reg[POINT_W-7:0], in_byte[5:0]};
    assign pend_dec = pending_reg - 2'd1;

    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        discard_next = discard_reg;
        do_push      = 1'b0;
        kind         = ERR_NONE;
        point        = '0;
        if (in_accept) begin
            if (discard_reg) begin
                if (in_eos) begin
                    discard_next = 1'b0;
                    pending_next = 2'd0;
                    partial_next = '0;
                end
            end else if (in_byte == 8'h00) begin
                do_push = 1'b1;
                kind    = ERR_NULL;
            end else if (pending_reg == 2'd0) begin
                if (in_byte[7] == 1'b0) begin
                    do_push = 1'b1;
                    point   = {13'd0, in_byte};
                end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                             in_byte[7:3] == 5'b11110) begin
                    if (in_eos) begin
                        do_push = 1'b1;
                        kind    = ERR_TRUNC;
                    end else if (in_byte[7:5] == 3'b110) begin
                        pending_next = 2'd1;
                        partial_next = {16'd0, in_byte[4:0]};
                    end else if (in_byte[7:4] == 4'b1110) begin
                        pending_next = 2'd2;
                        partial_next = {17'd0, in_byte[3:0]};
                    end else begin
                        pending_next = 2'd3;
                        partial_next = {18'd0, in_byte[2:0]};
                    end
                end else begin
                    do_push = 1'b1;
                    kind    = ERR_BAD_LEAD;
                end
            end else if (in_byte[7:6] != 2'b10) begin
                do_push = 1'b1;
                kind    = ERR_BAD_CONT;
            end else if (pend_dec != 2'd0) begin
                if (in_eos) begin
                    do_push = 1'b1;
                    kind    = ERR_TRUNC;
                end else begin
                    pending_next = pend_dec;
                    partial_next = shifted;
                end
            end else begin
                do_push = 1'b1;
                if (shifted > MAX_POINT) begin
                    kind = ERR_OVER_MAX;
                end else begin
                    point = shifted;
                end
            end

            if (do_push) begin
                pending_next = 2'd0;
                partial_next = '0;
                discard_next = (kind != ERR_NONE) && !in_eos;
            end
        end
    end

    assign push.valid       = do_push;
    assign push.entry.kind  = kind;
    assign push.entry.point = point;
    assign push.entry.eos   = in_eos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            discard_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            discard_reg <= discard_next;
        end
    end

endmodule

>>> rtl/u8u16_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_fifo
// Short queue of decoded entries between the front and the back.
// ----------------------------------------------------------------------------
module u8u16_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  u8u16_pkg::entry_bus_t  push,
    input  logic                   pop,
    output u8u16_pkg::entry_bus_t  head,
    output logic                   full
);
    import u8u16_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign do_wr = push.valid && !full;
    assign do_rd = pop && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

endmodule

>>> rtl/u8u16_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_back
// Turns queued entries into UTF-16 words, splitting surrogate pairs.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  u8u16_pkg::entry_bus_t           head,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [u8u16_pkg::UNIT_W-1:0]    m_tdata,
    output logic                            m_tlast,
    output logic [3:0]                      m_tuser
);
    import u8u16_pkg::*;

    logic               valid_reg, valid_next;
    logic               low_half_reg, low_half_next;
    logic [UNIT_W-1:0]  unit_reg, unit_next;
    err_kind_t          kind_reg, kind_next;
    logic               last_reg, last_next;
    logic               done_reg, done_next;

    logic               out_free;
    logic [19:0]        offset;
    logic               is_pair;

    assign out_free = !valid_reg || m_tready;
    assign offset   = 20'(head.entry.point - 21'h010000);
    assign is_pair  = (head.entry.kind == ERR_NONE) && (head.entry.point > BMP_MAX);

    always_comb begin
        valid_next    = valid_reg && !m_tready;
        low_half_next = low_half_reg;
        unit_next     = unit_reg;
        kind_next     = kind_reg;
        last_next     = last_reg;
        done_next     = done_reg;
        pop           = 1'b0;
        if (out_free && head.valid) begin
            valid_next = 1'b1;
            kind_next  = head.entry.kind;
            if (is_pair && !low_half_reg) begin
                // High surrogate first; the entry stays queued for the low half.
                unit_next     = {HI_SURR_TAG, offset[19:10]};
                last_next     = 1'b0;
                done_next     = 1'b0;
                low_half_next = 1'b1;
            end else begin
                if (is_pair) begin
                    unit_next = {LO_SURR_TAG, offset[9:0]};
                end else if (head.entry.kind == ERR_NONE) begin
                    unit_next = head.entry.point[UNIT_W-1:0];
                end else begin
                    unit_next = '0;
                end
                last_next     = 1'b1;
                done_next     = head.entry.eos;
                low_half_next = 1'b0;
                pop           = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            low_half_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            low_half_reg <= low_half_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg <= unit_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = unit_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {done_reg, kind_reg};

endmodule

>>> rtl/utf8_to_utf16_transcoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// Streaming UTF-8 to UTF-16 transcoder with error reporting per string.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata              | tlast          | tuser
//  s_      | in  | [7:0] byte_value   | end_of_string  | -
//  m_      | out | [15:0] code_unit   | last_of_run    | [2:0] error_kind, [3] string_done
//
//  One byte is accepted per cycle while the entry queue has room.
//  A result is loaded into the output register from the queue head once that
//  register is free; a surrogate pair yields two output words from one entry.
//  Reset (aresetn low, synchronous) clears the decoder state, the queue
//  pointers and count, and the output valid flag.
//  s_tready falls only when the queue of FIFO_DEPTH entries is full, which
//  happens when m_tready is held low.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_unit
    output logic        m_tlast,
    output logic [3:0]  m_tuser     // [2:0] error_kind, [3] string_done
);
    import u8u16_pkg::*;

    entry_bus_t push;
    entry_bus_t head;
    logic       full;
    logic       pop;
    logic       in_accept;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    u8u16_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_eos    (s_tlast),
        .push      (push)
    );

    u8u16_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (full)
    );

    u8u16_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/u8u16_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder's result stream.
// ----------------------------------------------------------------------------
module u8u16_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [3:0]  m_tuser
);
    import u8u16_pkg::*;

    // A stalled word stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // An error word carries no code unit and closes its run.
    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] != ERR_NONE) |-> (m_tdata == 16'h0000) && m_tlast)
        else $error("error word with data or without last");

    // Only the high half of a surrogate pair is not last of its run.
    a_high_surrogate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[15:10] == HI_SURR_TAG) &&
                                 (m_tuser[2:0] == ERR_NONE) && !m_tuser[3])
        else $error("non-final word is not a high surrogate");

    // The high half is followed by its low half once it is taken.
    a_low_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast &&
                                            (m_tdata[15:10] == LO_SURR_TAG))
        else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
